>>> rtl/mst_pkg.sv
`timescale 1ns / 1ps

package mst_pkg;

    // Tree geometry and field widths.
    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 10;
    localparam int NODE_COUNT = 2 * LEAVES;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int EDGE_BITS  = NODE_BITS + 1;
    localparam int CMP_BITS   = (NODE_BITS > POS_BITS) ? NODE_BITS : POS_BITS;

    // Request operation codes.
    localparam logic CMD_RAISE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic upd_leaf;
        logic upd_walk;
        logic qry_walk;
        logic out_load;
    } mst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic pos_ok;
        logic walk_last;
        logic qry_done;
    } mst_status_t;

    function automatic logic [VALUE_BITS-1:0] vmax(
        input logic [VALUE_BITS-1:0] a,
        input logic [VALUE_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/max_segment_tree_core.sv
`timescale 1ns / 1ps

// Channel  Handshake                   Payload
// in       in_valid / in_stall         cmd, position, new_value, range_low, range_high
// out      out_valid / out_stall       range_max
//
// An update makes one leaf write, then one ancestor write per level, all through the
// single write port of the node memory.
// In a query both range edges climb one level per cycle
// through the two read ports of the node memory.
// After reset a clearing pass writes zero to all 2*LEAVES nodes with in_stall high.
// A query result waits in an output register; the block takes the next request meanwhile.

module max_segment_tree_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [mst_pkg::POS_BITS-1:0]    position,
    input  logic [mst_pkg::VALUE_BITS-1:0]  new_value,
    input  logic [mst_pkg::POS_BITS-1:0]    range_low,
    input  logic [mst_pkg::POS_BITS-1:0]    range_high,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mst_pkg::VALUE_BITS-1:0]  range_max
);
    import mst_pkg::*;

    mst_cmd_t    ctl;
    mst_status_t status;

    // Sequencer for clearing, update walks and query walks.
    mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .status    (status),
        .ctl       (ctl),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // Node memory, walk registers and result register.
    mst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .position   (position),
        .new_value  (new_value),
        .range_low  (range_low),
        .range_high (range_high),
        .status     (status),
        .range_max  (range_max)
    );

endmodule

>>> rtl/mst_ctrl.sv
`timescale 1ns / 1ps

module mst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 cmd,
    input  logic                 out_stall,
    input  mst_pkg::mst_status_t status,
    output mst_pkg::mst_cmd_t    ctl,
    output logic                 in_stall,
    output logic                 out_valid
);
    import mst_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_WALK,
        ST_QRY_WALK,
        ST_QRY_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (cmd == CMD_QUERY)
                    begin
                        state_next = ST_QRY_WALK;
                    end
                    else if (status.pos_ok)
                    begin
                        state_next = ST_UPD_LEAF;
                    end
                end
            end
            ST_UPD_LEAF:
            begin
                ctl.upd_leaf = 1'b1;
                state_next   = ST_UPD_WALK;
            end
            ST_UPD_WALK:
            begin
                ctl.upd_walk = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_WALK:
            begin
                ctl.qry_walk = 1'b1;
                if (status.qry_done)
                begin
                    if (out_free)
                    begin
                        ctl.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_QRY_HOLD;
                    end
                end
            end
            ST_QRY_HOLD:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid is set by a result load and cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            in_stall_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= (state_next != ST_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/mst_dp.sv
`timescale 1ns / 1ps

module mst_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mst_pkg::mst_cmd_t                   ctl,
    input  logic [mst_pkg::POS_BITS-1:0]        position,
    input  logic [mst_pkg::VALUE_BITS-1:0]      new_value,
    input  logic [mst_pkg::POS_BITS-1:0]        range_low,
    input  logic [mst_pkg::POS_BITS-1:0]        range_high,
    output mst_pkg::mst_status_t                status,
    output logic [mst_pkg::VALUE_BITS-1:0]      range_max
);
    import mst_pkg::*;

    localparam logic [CMP_BITS-1:0]  LAST_LEAF = CMP_BITS'(LEAVES - 1);
    localparam logic [CMP_BITS-1:0]  LEAF_CNT  = CMP_BITS'(LEAVES);
    localparam logic [EDGE_BITS-1:0] EDGE_BASE = EDGE_BITS'(LEAVES);
    localparam logic [NODE_BITS-1:0] NODE_BASE = NODE_BITS'(LEAVES);
    localparam logic [NODE_BITS-1:0] NODE_LAST = NODE_BITS'(NODE_COUNT - 1);
    localparam logic [NODE_BITS-1:0] NODE_ROOT = NODE_BITS'(1);

    // Node memory in heap order; node 1 is the root.
    logic [VALUE_BITS-1:0] node_mem [NODE_COUNT];

    logic [NODE_BITS-1:0]  clr_addr_reg;
    logic [NODE_BITS-1:0]  k_reg, k_next, k_parent;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [EDGE_BITS-1:0]  l_reg, l_next, r_reg, r_next, r_dec;
    logic                  take_a_reg, take_a_next, take_b_reg, take_b_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [VALUE_BITS-1:0] range_max_reg;

    logic [CMP_BITS-1:0]   lo_cmp, hi_cmp, hi_clamp;
    logic                  range_empty;
    logic [NODE_BITS-1:0]  rd_addr_a, rd_addr_b;
    logic                  wr_en;
    logic [NODE_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [VALUE_BITS-1:0] leaf_max, walk_max, sel_a, sel_b;

    // Query bounds: clamp the high bound and detect an empty range.
    assign lo_cmp      = CMP_BITS'(range_low);
    assign hi_cmp      = CMP_BITS'(range_high);
    assign hi_clamp    = (hi_cmp > LAST_LEAF) ? LAST_LEAF : hi_cmp;
    assign range_empty = (lo_cmp > hi_clamp);

    assign k_parent = k_reg >> 1;
    assign r_dec    = r_reg - EDGE_BITS'(1);
    assign leaf_max = vmax(rd_a_reg, val_reg);
    assign walk_max = vmax(val_reg, rd_b_reg);
    assign sel_a    = take_a_reg ? rd_a_reg : '0;
    assign sel_b    = take_b_reg ? rd_b_reg : '0;

    // Update walk: node index and running value.
    always_comb
    begin
        k_next   = k_reg;
        val_next = val_reg;
        if (ctl.load)
        begin
            k_next   = NODE_BITS'(position) + NODE_BASE;
            val_next = new_value;
        end
        else if (ctl.upd_leaf)
        begin
            val_next = leaf_max;
        end
        else if (ctl.upd_walk)
        begin
            k_next   = k_parent;
            val_next = walk_max;
        end
    end

    // Query walk: bottom-up bounds and which nodes join the result.
    always_comb
    begin
        l_next      = l_reg;
        r_next      = r_reg;
        take_a_next = 1'b0;
        take_b_next = 1'b0;
        if (ctl.load)
        begin
            if (range_empty)
            begin
                l_next = '0;
                r_next = '0;
            end
            else
            begin
                l_next = EDGE_BITS'(lo_cmp) + EDGE_BASE;
                r_next = EDGE_BITS'(hi_clamp) + EDGE_BASE + EDGE_BITS'(1);
            end
        end
        else if (ctl.qry_walk && !status.qry_done)
        begin
            take_a_next = l_reg[0];
            take_b_next = r_reg[0];
            l_next      = (l_reg + EDGE_BITS'(l_reg[0])) >> 1;
            r_next      = (r_reg - EDGE_BITS'(r_reg[0])) >> 1;
        end
    end

    // Accumulate the nodes read in the previous cycle.
    assign acc_next = ctl.load ? '0 : vmax(acc_reg, vmax(sel_a, sel_b));

    // Read addresses follow the walk that is running.
    always_comb
    begin
        if (ctl.qry_walk)
        begin
            rd_addr_a = l_reg[NODE_BITS-1:0];
            rd_addr_b = r_dec[NODE_BITS-1:0];
        end
        else
        begin
            rd_addr_a = k_next;
            rd_addr_b = k_next ^ NODE_ROOT;
        end
    end

    // Single write port: clearing pass, leaf write or ancestor write.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (ctl.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.upd_leaf)
        begin
            wr_en   = 1'b1;
            wr_addr = k_reg;
            wr_data = leaf_max;
        end
        else if (ctl.upd_walk)
        begin
            wr_en   = 1'b1;
            wr_addr = k_parent;
            wr_data = walk_max;
        end
    end

    // Node memory with two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= node_mem[rd_addr_a];
        rd_b_reg <= node_mem[rd_addr_b];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            take_a_reg   <= 1'b0;
            take_b_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + NODE_BITS'(1);
            end
            take_a_reg <= take_a_next;
            take_b_reg <= take_b_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        val_reg <= val_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        if (ctl.out_load)
        begin
            range_max_reg <= acc_next;
        end
    end

    // Status for the controller.
    assign status.clear_last = (clr_addr_reg == NODE_LAST);
    assign status.pos_ok     = (CMP_BITS'(position) < LEAF_CNT);
    assign status.walk_last  = (k_parent == NODE_ROOT);
    assign status.qry_done   = !(l_reg < r_reg);

    assign range_max = range_max_reg;

endmodule

>>> rtl/mst_checker.sv
`timescale 1ns / 1ps

module mst_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            cmd,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [mst_pkg::VALUE_BITS-1:0]  range_max
);
    import mst_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(range_max))
        else $error("stalled result changed or dropped");

    // An accepted update keeps the input stalled for the leaf write and at least one level.
    a_upd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_RAISE) |=> in_stall ##1 in_stall)
        else $error("update request did not occupy the block");

    // An accepted query keeps the input stalled while the range is walked.
    a_qry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_QUERY) |=> in_stall)
        else $error("query request did not occupy the block");

    // A new result only appears at the end of a query walk.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a query walk");

endmodule

bind max_segment_tree_core mst_checker u_mst_checker (.*);

>>> dv/tb_max_segment_tree_core.sv
`timescale 1ns / 1ps

module tb_max_segment_tree_core;

    import mst_pkg::*;

    // Cycles of the long output hold-off, and the quiet-cycle limit of the watchdog.
    // The limit covers the clearing pass after reset and the hold-off several times over.
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 12000;

    typedef struct packed {
        logic                  op;
        logic [POS_BITS-1:0]   pos;
        logic [VALUE_BITS-1:0] val;
        logic [POS_BITS-1:0]   lo;
        logic [POS_BITS-1:0]   hi;
    } seg_req_t;

    typedef struct {
        logic [VALUE_BITS-1:0] peak;
        logic [POS_BITS-1:0]   lo;
        logic [POS_BITS-1:0]   hi;
    } peak_exp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = CMD_RAISE;
    logic [POS_BITS-1:0]   position = '0;
    logic [VALUE_BITS-1:0] new_value = '0;
    logic [POS_BITS-1:0]   range_low = '0;
    logic [POS_BITS-1:0]   range_high = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VALUE_BITS-1:0] range_max;

    // Shadow copy of the leaf values and the queues around the block.
    logic [VALUE_BITS-1:0] leaf_val [0:LEAVES-1];
    seg_req_t              pending_reqs [$];
    peak_exp_t             peak_expected [$];

    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   holds_asked = 0;
    int   holds_served = 0;
    int   hold_left = 0;
    int   queued_cnt = 0;
    int   accepted_cnt = 0;
    int   quiet_cycles = 0;
    int   error_cnt = 0;
    int   raise_cnt = 0;
    int   query_cnt = 0;
    int   empty_cnt = 0;
    int   checked_cnt = 0;

    max_segment_tree_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .position   (position),
        .new_value  (new_value),
        .range_low  (range_low),
        .range_high (range_high),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .range_max  (range_max)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Leaf raise: the leaf keeps the larger of its old and new value.
    function automatic void raise_leaf(input logic [POS_BITS-1:0] pos,
                                       input logic [VALUE_BITS-1:0] val);
        if (pos < LEAVES && val > leaf_val[pos])
            leaf_val[pos] = val;
    endfunction

    // Range maximum over the inclusive range, with the high bound clamped.
    function automatic logic [VALUE_BITS-1:0] range_peak(input int lo, input int hi);
        logic [VALUE_BITS-1:0] peak;
        peak = '0;
        if (hi > LEAVES - 1)
            hi = LEAVES - 1;
        for (int i = lo; i <= hi; i++)
            if (leaf_val[i] > peak)
                peak = leaf_val[i];
        return peak;
    endfunction

    function automatic seg_req_t make_req(input logic op, input int pos, input logic [31:0] val,
                                          input int lo, input int hi);
        seg_req_t r;
        r.op  = op;
        r.pos = pos[POS_BITS-1:0];
        r.val = val;
        r.lo  = lo[POS_BITS-1:0];
        r.hi  = hi[POS_BITS-1:0];
        return r;
    endfunction

    // Random request: raises with values of random magnitude, queries of mixed shapes.
    // Fields that the operation does not use carry random bits as well.
    function automatic seg_req_t random_req();
        seg_req_t r;
        int       shape;
        int       a;
        int       b;
        r.op  = ($urandom_range(0, 99) < 45) ? CMD_RAISE : CMD_QUERY;
        r.pos = ($urandom_range(0, 99) < 30) ? POS_BITS'($urandom_range(0, 63))
                                             : POS_BITS'($urandom);
        shape = $urandom_range(0, 99);
        if (shape < 3)
            r.val = '0;
        else if (shape < 5)
            r.val = '1;
        else
            r.val = $urandom >> $urandom_range(0, 31);
        shape = $urandom_range(0, 99);
        if (shape < 10)
        begin
            a = $urandom_range(1, LEAVES - 1);
            b = $urandom_range(0, a - 1);
        end
        else if (shape < 25)
        begin
            a = $urandom_range(0, LEAVES - 1);
            b = a;
        end
        else if (shape < 40)
        begin
            a = $urandom_range(0, 63);
            b = $urandom_range(a, 63);
        end
        else if (shape < 45)
        begin
            a = 0;
            b = LEAVES - 1;
        end
        else
        begin
            a = $urandom_range(0, LEAVES - 1);
            b = $urandom_range(a, LEAVES - 1);
        end
        r.lo = POS_BITS'(a);
        r.hi = POS_BITS'(b);
        return r;
    endfunction

    task automatic queue_req(input seg_req_t r);
        pending_reqs = {pending_reqs, r};
        queued_cnt++;
    endtask

    task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
                                   input logic [VALUE_BITS-1:0] want);
        $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        error_cnt++;
    endtask

    // Wait until every queued request is taken and every query result has come back.
    task automatic wait_drain();
        while (accepted_cnt != queued_cnt || peak_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            queue_req(random_req());
        wait_drain();
    endtask

    // Request driver: a stalled request stays put, otherwise the next one may be offered.
    always @(negedge clk)
    begin : drive_req
        seg_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                in_valid   <= 1'b1;
                cmd        <= nxt.op;
                position   <= nxt.pos;
                new_value  <= nxt.val;
                range_low  <= nxt.lo;
                range_high <= nxt.hi;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result stall: a long hold-off when asked for, random stalls otherwise.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            out_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: predicts on each accepted request, checks each accepted result.
    always @(posedge clk)
    begin : watch_ports
        peak_exp_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                accepted_cnt++;
                if (cmd == CMD_QUERY)
                begin
                    want.peak = range_peak(range_low, range_high);
                    want.lo   = range_low;
                    want.hi   = range_high;
                    peak_expected = {peak_expected, want};
                    query_cnt++;
                    if (range_low > range_high)
                        empty_cnt++;
                end
                else
                begin
                    raise_leaf(position, new_value);
                    raise_cnt++;
                end
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (peak_expected.size() == 0)
                    report_mismatch("result with no query pending", range_max, '0);
                else
                begin
                    want = peak_expected.pop_front();
                    checked_cnt++;
                    if (range_max !== want.peak)
                        report_mismatch($sformatf("range_max for [%0d..%0d]", want.lo, want.hi),
                                        range_max, want.peak);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("tb_max_segment_tree_core: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < LEAVES; i++)
            leaf_val[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty tree, extreme positions and values, odd range shapes.
        send_idle_pct  = 16;
        recv_stall_pct = 50;
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 0, LEAVES - 1));
        queue_req(make_req(CMD_RAISE, 0, 32'd5, 1023, 0));
        queue_req(make_req(CMD_RAISE, LEAVES - 1, 32'hFFFF_FFFF, 0, 0));
        queue_req(make_req(CMD_RAISE, 10'h155, 32'h5555_5555, 10'h2AA, 10'h155));
        queue_req(make_req(CMD_RAISE, 10'h2AA, 32'hAAAA_AAAA, 0, 0));
        queue_req(make_req(CMD_RAISE, 512, 32'h8000_0000, 0, 0));
        queue_req(make_req(CMD_RAISE, 0, 32'd3, 0, 0));
        queue_req(make_req(CMD_RAISE, 1, 32'h0, 0, 0));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 0, LEAVES - 1));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 0, 0));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 1, 1));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 1, LEAVES - 2));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, LEAVES - 1, LEAVES - 1));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 5, 4));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, LEAVES - 1, 0));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 512, 512));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 1, 511));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 10'h156, 10'h2A9));
        queue_req(make_req(CMD_QUERY, 10'h3FF, 32'hFFFF_FFFF, 10'h155, 10'h2AA));
        queue_req(make_req(CMD_QUERY, 0, 32'h0, 513, LEAVES - 2));
        wait_drain();

        // Random part under changing idle patterns.
        run_random(520);
        send_idle_pct  = 50;
        recv_stall_pct = 16;
        run_random(520);

        // Long result hold-off while queries keep coming, so the input backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked++;
        run_random(80);

        run_random(580);

        repeat (40) @(negedge clk);
        if (peak_expected.size() != 0)
            report_mismatch("query results never returned", '0, peak_expected.size());
        $display("Covered %0d raises and %0d queries (%0d empty ranges), %0d results checked.",
                 raise_cnt, query_cnt, empty_cnt, checked_cnt);
        $display("Idle mixes on both sides, a long result hold-off and drain pauses included.");
        if (error_cnt == 0)
            $display("tb_max_segment_tree_core: done, clean");
        else
            $display("tb_max_segment_tree_core: done, errors");
        $finish;
    end

endmodule
